/* src/gram_schmidt_3x3_macros.svh */
// Assertion macros used by the gram_schmidt_3x3 top-level RTL file.
`ifndef GRAM_SCHMIDT_3X3_MACROS_SVH
`define GRAM_SCHMIDT_3X3_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked while out of reset.
`define GS3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GS3_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GS3_ASSERT(lbl, prop, msg)
`define GS3_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* src/gs3_pkg.sv */
// Types, widths and helpers shared by the Gram-Schmidt pipeline and its divider.
`default_nettype none
package gs3_pkg;
	localparam int NV       = 3;            // vector dimension
	localparam int DW       = 16;           // Q8.8 input width
	localparam int OW       = 24;           // Q10.14 output width
	localparam int FRAC_SH  = 6;            // Q8.8 to Q10.14 scale
	localparam int RND_SH   = FRAC_SH + 1;  // one extra bit for rounding
	localparam int QB       = OW;           // quotient bits of the doubled result
	localparam int NUM_W    = 64;           // divider numerator width
	localparam int DEN_W    = 46;           // divider denominator width
	localparam int REM_W    = NUM_W + RND_SH;
	localparam int DIV_LAT  = QB + 2;       // divider latency in cycles
	localparam int AA_W     = 2 * DW;       // a.a, unsigned
	localparam int AB_W     = 2 * DW + 1;   // a.b and a.c, signed
	localparam int PA_W     = DW + AB_W;    // products feeding the first numerators
	localparam int NB_W     = PA_W + 1;     // first numerators
	localparam int CB_W     = DW + OW + 2;  // c.b1, signed
	localparam int OUT_HI   = 2 ** (OW - 1) - 1;
	localparam int OUT_LO   = -(2 ** (OW - 1));

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_A_ZERO  = 2'd1,
		ST_B1_ZERO = 2'd2
	} status_t;

	typedef logic signed [DW-1:0]    in_t;
	typedef logic signed [OW-1:0]    out_t;
	typedef logic signed [OW:0]      quo_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [DEN_W-1:0]        den_t;

	// Clamp a slightly wider signed value to the Q10.14 output range.
	function automatic out_t sat_out(input logic signed [OW+1:0] v);
		logic signed [OW+1:0] hi;
		logic signed [OW+1:0] lo;
		hi = (OW+2)'(OUT_HI);
		lo = (OW+2)'(OUT_LO);
		if (v > hi) begin
			sat_out = hi[OW-1:0];
		end else if (v < lo) begin
			sat_out = lo[OW-1:0];
		end else begin
			sat_out = v[OW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

/* src/gs3_div.sv */
// Pipelined restoring divider: round(num * 64 / den), ties away from zero.
`default_nettype none
module gs3_div import gs3_pkg::*; (
	input  logic clk,
	input  logic en,
	input  num_t num,
	input  den_t den,
	output quo_t quo
);
	logic [NUM_W-1:0] mag;
	logic [REM_W-1:0] rem_s [QB];
	den_t             den_s [QB];
	logic             neg_s [QB+1];
	logic [QB-1:0]    q_s   [QB+1];
	logic [QB:0]      qr;
	quo_t             quo_q;

	// Entry stage: sign and magnitude, scaled by 128 for the half step.
	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= num[NUM_W-1];
			rem_s[0] <= {mag, {RND_SH{1'b0}}};
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 0; j < QB; j++) begin : g_step
		localparam int K = QB - 1 - j;
		logic [REM_W-1:0] dsh;
		logic [REM_W:0]   diff;

		assign dsh  = REM_W'(den_s[j]) << K;
		assign diff = {1'b0, rem_s[j]} - {1'b0, dsh};

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[j+1] <= neg_s[j];
				q_s[j+1]   <= diff[REM_W] ? q_s[j] : (q_s[j] | (QB'(1) << K));
			end
		end

		if (j < QB - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1] <= diff[REM_W] ? rem_s[j] : diff[REM_W-1:0];
					den_s[j+1] <= den_s[j];
				end
			end
		end
	end

	// Halve the doubled quotient with rounding and restore the sign.
	assign qr = ({1'b0, q_s[QB]} + (QB+1)'(1)) >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_s[QB] ? quo_t'(-qr) : quo_t'(qr);
		end
	end

	assign quo = quo_q;
endmodule
`default_nettype wire

/* src/gram_schmidt_3x3.sv */
// Top level: pipelined Gram-Schmidt orthogonalization of three 3-D vectors.
//
//   Channel | Direction | Handshake           | Payload
//   input   | in        | in_valid / in_stall | a_*, b_*, c_* (Q8.8)
//   output  | out       | out_valid/out_stall | echo_a_*, ortho_b_*, ortho_c_*, status
//
// One triple enters per cycle while in_stall is low; each result is registered at the output.
// The path runs through two 26-stage dividers in series, one quotient bit per inner stage,
// plus four multiply/add stages ahead of each and one output stage.
// Reset clears only the valid bits; there is no state kept between triples.
// A stalled result freezes the whole pipeline, so in_stall follows it at once.
`default_nettype none
`include "gram_schmidt_3x3_macros.svh"
module gram_schmidt_3x3 import gs3_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_t         a_x,
	input  in_t         a_y,
	input  in_t         a_z,
	input  in_t         b_x,
	input  in_t         b_y,
	input  in_t         b_z,
	input  in_t         c_x,
	input  in_t         c_y,
	input  in_t         c_z,
	output logic        out_valid,
	input  logic        out_stall,
	output in_t         echo_a_x,
	output in_t         echo_a_y,
	output in_t         echo_a_z,
	output out_t        ortho_b_x,
	output out_t        ortho_b_y,
	output out_t        ortho_b_z,
	output out_t        ortho_c_x,
	output out_t        ortho_c_y,
	output out_t        ortho_c_z,
	output logic [1:0]  status
);
	typedef struct packed {
		in_t [NV-1:0] a;
		in_t [NV-1:0] b;
		in_t [NV-1:0] c;
		logic         aa_zero;
	} car1_t;

	typedef struct packed {
		in_t  [NV-1:0] a;
		out_t [NV-1:0] b1;
		out_t [NV-1:0] cp;
		logic          aa_zero;
		logic          bb_zero;
	} car2_t;

	in_t a_in [NV];
	in_t b_in [NV];
	in_t c_in [NV];
	logic en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [DIV_LAT-1:0] vd1_q, vd2_q;
	logic vld_q;

	in_t a_s1 [NV], b_s1 [NV], c_s1 [NV];
	logic signed [2*DW-1:0] paa_s1 [NV], pab_s1 [NV], pac_s1 [NV];

	logic [AA_W-1:0] aa_s2;
	logic signed [AB_W-1:0] ab_s2, ac_s2;
	in_t a_s2 [NV], b_s2 [NV], c_s2 [NV];

	logic [AA_W-1:0] aa_s3;
	logic aa_zero_s3;
	logic signed [PA_W-1:0] pba_s3 [NV], pab_s3 [NV], pca_s3 [NV], pac_s3 [NV];
	in_t a_s3 [NV], b_s3 [NV], c_s3 [NV];

	logic [AA_W-1:0] aa_s4;
	logic signed [NB_W-1:0] numb_s4 [NV], numc_s4 [NV];
	car1_t car_s4;

	car1_t car1_q [DIV_LAT];
	car1_t cd;
	quo_t qb [NV], qc [NV];

	out_t b1_s5 [NV], cp_s5 [NV];
	in_t a_s5 [NV], c_s5 [NV];
	logic aa_zero_s5;

	logic signed [2*OW-1:0] pbb_s6 [NV];
	logic signed [DW+OW-1:0] pcb_s6 [NV];
	in_t a_s6 [NV];
	out_t b1_s6 [NV], cp_s6 [NV];
	logic aa_zero_s6;

	den_t bb_s7;
	logic signed [CB_W-1:0] cb_s7;
	in_t a_s7 [NV];
	out_t b1_s7 [NV], cp_s7 [NV];
	logic aa_zero_s7;
	logic signed [CB_W+OW-1:0] prod2 [NV];

	den_t bb_s8;
	num_t num2_s8 [NV];
	car2_t car_s8;

	car2_t car2_q [DIV_LAT];
	car2_t ce;
	quo_t qp [NV];

	in_t echo_q [NV];
	out_t ob_q [NV], oc_q [NV];
	status_t status_q;

	assign a_in[0] = a_x;
	assign a_in[1] = a_y;
	assign a_in[2] = a_z;
	assign b_in[0] = b_x;
	assign b_in[1] = b_y;
	assign b_in[2] = b_z;
	assign c_in[0] = c_x;
	assign c_in[1] = c_y;
	assign c_in[2] = c_z;

	// The pipeline moves unless a finished result is held by the consumer.
	assign en       = !vld_q || !out_stall;
	assign in_stall = !en;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			vd1_q <= '0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			vd2_q <= '0;
			vld_q <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			vd1_q <= {vd1_q[DIV_LAT-2:0], v_s4};
			v_s5  <= vd1_q[DIV_LAT-1];
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			vd2_q <= {vd2_q[DIV_LAT-2:0], v_s8};
			vld_q <= vd2_q[DIV_LAT-1];
		end
	end

	// Stages 1 to 4: dot products with a and the first numerators.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NV; i++) begin
				a_s1[i]   <= a_in[i];
				b_s1[i]   <= b_in[i];
				c_s1[i]   <= c_in[i];
				paa_s1[i] <= a_in[i] * a_in[i];
				pab_s1[i] <= a_in[i] * b_in[i];
				pac_s1[i] <= a_in[i] * c_in[i];
			end

			aa_s2 <= AA_W'($unsigned(paa_s1[0]) + $unsigned(paa_s1[1])
				+ $unsigned(paa_s1[2]));
			ab_s2 <= AB_W'(pab_s1[0]) + AB_W'(pab_s1[1]) + AB_W'(pab_s1[2]);
			ac_s2 <= AB_W'(pac_s1[0]) + AB_W'(pac_s1[1]) + AB_W'(pac_s1[2]);
			for (int i = 0; i < NV; i++) begin
				a_s2[i] <= a_s1[i];
				b_s2[i] <= b_s1[i];
				c_s2[i] <= c_s1[i];
			end

			aa_s3      <= aa_s2;
			aa_zero_s3 <= (aa_s2 == '0);
			for (int i = 0; i < NV; i++) begin
				pba_s3[i] <= b_s2[i] * $signed({1'b0, aa_s2});
				pab_s3[i] <= ab_s2 * a_s2[i];
				pca_s3[i] <= c_s2[i] * $signed({1'b0, aa_s2});
				pac_s3[i] <= ac_s2 * a_s2[i];
				a_s3[i]   <= a_s2[i];
				b_s3[i]   <= b_s2[i];
				c_s3[i]   <= c_s2[i];
			end

			aa_s4          <= aa_s3;
			car_s4.aa_zero <= aa_zero_s3;
			for (int i = 0; i < NV; i++) begin
				numb_s4[i]  <= NB_W'(pba_s3[i]) - NB_W'(pab_s3[i]);
				numc_s4[i]  <= NB_W'(pca_s3[i]) - NB_W'(pac_s3[i]);
				car_s4.a[i] <= a_s3[i];
				car_s4.b[i] <= b_s3[i];
				car_s4.c[i] <= c_s3[i];
			end
		end
	end

	// Side data waits alongside the first divider bank.
	always_ff @(posedge clk) begin
		if (en) begin
			car1_q[0] <= car_s4;
			for (int k = 1; k < DIV_LAT; k++) begin
				car1_q[k] <= car1_q[k-1];
			end
		end
	end

	for (genvar i = 0; i < NV; i++) begin : g_div_a
		gs3_div u_div_b (
			.clk (clk),
			.en  (en),
			.num (NUM_W'(numb_s4[i])),
			.den (DEN_W'(aa_s4)),
			.quo (qb[i])
		);
		gs3_div u_div_c (
			.clk (clk),
			.en  (en),
			.num (NUM_W'(numc_s4[i])),
			.den (DEN_W'(aa_s4)),
			.quo (qc[i])
		);
	end

	assign cd = car1_q[DIV_LAT-1];

	// Stages 5 to 8: b1, the a-free part of c, then dot products with b1.
	always_ff @(posedge clk) begin
		if (en) begin
			aa_zero_s5 <= cd.aa_zero;
			for (int i = 0; i < NV; i++) begin
				b1_s5[i] <= sat_out(cd.aa_zero
					? ((OW+2)'($signed(cd.b[i])) <<< FRAC_SH) : (OW+2)'(qb[i]));
				cp_s5[i] <= sat_out(cd.aa_zero
					? ((OW+2)'($signed(cd.c[i])) <<< FRAC_SH) : (OW+2)'(qc[i]));
				a_s5[i]  <= cd.a[i];
				c_s5[i]  <= cd.c[i];
			end

			aa_zero_s6 <= aa_zero_s5;
			for (int i = 0; i < NV; i++) begin
				pbb_s6[i] <= b1_s5[i] * b1_s5[i];
				pcb_s6[i] <= c_s5[i] * b1_s5[i];
				a_s6[i]   <= a_s5[i];
				b1_s6[i]  <= b1_s5[i];
				cp_s6[i]  <= cp_s5[i];
			end

			aa_zero_s7 <= aa_zero_s6;
			bb_s7 <= DEN_W'($unsigned(pbb_s6[0])) + DEN_W'($unsigned(pbb_s6[1]))
				+ DEN_W'($unsigned(pbb_s6[2]));
			cb_s7 <= CB_W'(pcb_s6[0]) + CB_W'(pcb_s6[1]) + CB_W'(pcb_s6[2]);
			for (int i = 0; i < NV; i++) begin
				a_s7[i]  <= a_s6[i];
				b1_s7[i] <= b1_s6[i];
				cp_s7[i] <= cp_s6[i];
			end

			bb_s8          <= bb_s7;
			car_s8.aa_zero <= aa_zero_s7;
			car_s8.bb_zero <= (bb_s7 == '0);
			for (int i = 0; i < NV; i++) begin
				num2_s8[i]   <= NUM_W'(prod2[i]);
				car_s8.a[i]  <= a_s7[i];
				car_s8.b1[i] <= b1_s7[i];
				car_s8.cp[i] <= cp_s7[i];
			end
		end
	end

	for (genvar i = 0; i < NV; i++) begin : g_prod2
		assign prod2[i] = cb_s7 * b1_s7[i];
	end

	// Side data waits alongside the second divider bank.
	always_ff @(posedge clk) begin
		if (en) begin
			car2_q[0] <= car_s8;
			for (int k = 1; k < DIV_LAT; k++) begin
				car2_q[k] <= car2_q[k-1];
			end
		end
	end

	for (genvar i = 0; i < NV; i++) begin : g_div_b1
		gs3_div u_div_p (
			.clk (clk),
			.en  (en),
			.num (num2_s8[i]),
			.den (bb_s8),
			.quo (qp[i])
		);
	end

	assign ce = car2_q[DIV_LAT-1];

	// Output stage: remove the b1 projection and set the status code.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NV; i++) begin
				echo_q[i] <= ce.a[i];
				ob_q[i]   <= ce.b1[i];
				oc_q[i]   <= sat_out((OW+2)'($signed(ce.cp[i]))
					- (ce.bb_zero ? (OW+2)'(0) : (OW+2)'(qp[i])));
			end
			if (ce.aa_zero) begin
				status_q <= ST_A_ZERO;
			end else if (ce.bb_zero) begin
				status_q <= ST_B1_ZERO;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	assign out_valid = vld_q;
	assign echo_a_x  = echo_q[0];
	assign echo_a_y  = echo_q[1];
	assign echo_a_z  = echo_q[2];
	assign ortho_b_x = ob_q[0];
	assign ortho_b_y = ob_q[1];
	assign ortho_b_z = ob_q[2];
	assign ortho_c_x = oc_q[0];
	assign ortho_c_y = oc_q[1];
	assign ortho_c_z = oc_q[2];
	assign status    = status_q;

	// The first-vector-zero code matches an all-zero echoed a.
	`GS3_ASSERT(a_status_a_zero, out_valid |-> ((status == ST_A_ZERO) == (echo_a_x == '0 && echo_a_y == '0 && echo_a_z == '0)), "status does not match zero first vector")
	// With a nonzero, the second code matches an all-zero b1.
	`GS3_ASSERT(a_status_b1_zero, out_valid && status != ST_A_ZERO |-> ((status == ST_B1_ZERO) == (ortho_b_x == '0 && ortho_b_y == '0 && ortho_b_z == '0)), "status does not match zero b1")
	// No result is offered while reset is applied.
	`GS3_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")
endmodule
`default_nettype wire
